// File: rtl/der_pkg.sv
// ----------------------------------------------------------------------------
// der_pkg
// Shared types and constants for the DER REAL (binary64) encoder.
// ----------------------------------------------------------------------------
package der_pkg;

    // Most content octets a single value can produce
    localparam int MAX_OCTETS = 10;

    // Special-value content octets
    localparam logic [7:0] OCT_PINF  = 8'h40;
    localparam logic [7:0] OCT_NINF  = 8'h41;
    localparam logic [7:0] OCT_NAN   = 8'h42;
    localparam logic [7:0] OCT_NZERO = 8'h43;
    localparam logic [7:0] OCT_PZERO = 8'h00;

    // Header octet bits for the binary form
    localparam logic [7:0] HDR_BIN  = 8'h80;
    localparam logic [7:0] HDR_NEG  = 8'h40;
    localparam logic [7:0] HDR_EXP2 = 8'h01;

    // Exponent offsets: bias plus fraction width, and the subnormal exponent
    localparam logic signed [11:0] EXP_NORM_OFS = 12'sd1075;
    localparam logic signed [11:0] EXP_SUBNORM  = -12'sd1074;

    // Decoded value travelling down the pipeline
    typedef struct packed {
        logic               neg;
        logic               special;  // single-octet encoding
        logic [7:0]         sp_oct;
        logic               empty;    // positive zero
        logic signed [11:0] exp;
        logic [52:0]        mant;
    } t_dec;

    // Decoded value plus trailing-zero shift
    typedef struct packed {
        t_dec       d;
        logic [5:0] sh;
    } t_ctz;

    // Fully built encoding handed to the serializer
    typedef struct packed {
        logic [MAX_OCTETS-1:0][7:0] oct;  // oct[0] goes out first
        logic [3:0]                 n;
        logic                       empty;
    } t_pkt;

endpackage

// File: rtl/der_dec.sv
// ----------------------------------------------------------------------------
// der_dec
// Stage 1: splits the binary64 pattern, classifies special values and
// forms the integer mantissa and unbiased exponent.
// ----------------------------------------------------------------------------
module der_dec import der_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output t_dec        o_dec
);

    logic        r_v;
    t_dec        r_dec;
    t_dec        n_dec;
    logic        rdy;
    logic        neg;
    logic [10:0] ebits;
    logic [51:0] frac;
    logic        e_max;
    logic        e_zero;
    logic        f_zero;

    assign rdy     = !r_v || !i_stall;
    assign o_stall = !rdy;
    assign o_valid = r_v;
    assign o_dec   = r_dec;

    // field split and classification
    always_comb begin
        neg    = i_float_bits[63];
        ebits  = i_float_bits[62:52];
        frac   = i_float_bits[51:0];
        e_max  = &ebits;
        e_zero = (ebits == 11'd0);
        f_zero = (frac == 52'd0);

        n_dec.neg     = neg;
        n_dec.special = e_max || (e_zero && f_zero);
        n_dec.empty   = e_zero && f_zero && !neg;
        if (e_max) begin
            n_dec.sp_oct = !f_zero ? OCT_NAN : (neg ? OCT_NINF : OCT_PINF);
        end else begin
            n_dec.sp_oct = neg ? OCT_NZERO : OCT_PZERO;
        end
        if (e_zero) begin
            n_dec.exp = EXP_SUBNORM;
        end else begin
            n_dec.exp = $signed({1'b0, ebits}) - EXP_NORM_OFS;
        end
        n_dec.mant = {!e_zero, frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_dec <= n_dec;
        end
    end

endmodule

// File: rtl/der_ctz.sv
// ----------------------------------------------------------------------------
// der_ctz
// Stages 2 and 3: trailing-zero count of the 53-bit mantissa. Stage 2
// counts inside each byte, stage 3 picks the lowest nonzero byte.
// ----------------------------------------------------------------------------
module der_ctz import der_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_dec i_dec,
    output logic o_valid,
    input  logic i_stall,
    output t_ctz o_ctz
);

    localparam int NB = 7;

    // trailing zeros of one byte (only used when the byte is nonzero)
    function automatic logic [2:0] ctz8(input logic [7:0] b);
        logic [2:0] c;
        c = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (b[k]) begin
                c = 3'(k);
            end
        end
        return c;
    endfunction

    logic [1:0]            r_v;
    logic [1:0]            rdy;
    t_dec                  r_dec2;
    logic [NB-1:0]         r_nz;
    logic [NB-1:0][2:0]    r_tzb;
    t_ctz                  r_ctz;
    logic [55:0]           m56;
    logic [NB-1:0]         n_nz;
    logic [NB-1:0][2:0]    n_tzb;
    logic [5:0]            n_sh;

    assign rdy[1]  = !r_v[1] || !i_stall;
    assign rdy[0]  = !r_v[0] || rdy[1];
    assign o_stall = !rdy[0];
    assign o_valid = r_v[1];
    assign o_ctz   = r_ctz;

    // per-byte zero flags and in-byte counts
    always_comb begin
        m56 = {3'b000, i_dec.mant};
        for (int b = 0; b < NB; b++) begin
            n_nz[b]  = |m56[8*b +: 8];
            n_tzb[b] = ctz8(m56[8*b +: 8]);
        end
    end

    // lowest nonzero byte wins
    always_comb begin
        n_sh = 6'd0;
        for (int b = NB - 1; b >= 0; b--) begin
            if (r_nz[b]) begin
                n_sh = {3'(b), r_tzb[b]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 2'b00;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (rdy[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_dec2 <= i_dec;
            r_nz   <= n_nz;
            r_tzb  <= n_tzb;
        end
        if (rdy[1] && r_v[0]) begin
            r_ctz.d  <= r_dec2;
            r_ctz.sh <= n_sh;
        end
    end

endmodule

// File: rtl/der_pack.sv
// ----------------------------------------------------------------------------
// der_pack
// Stages 4 to 6: makes the mantissa odd, sizes exponent and mantissa,
// then lays out the full content octet string.
// ----------------------------------------------------------------------------
module der_pack import der_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_ctz i_ctz,
    output logic o_valid,
    input  logic i_stall,
    output t_pkt o_pkt
);

    logic [2:0]  r_v;
    logic [2:0]  rdy;
    t_dec        r_d4;
    t_dec        r_d5;
    logic        r_long;
    logic [2:0]  r_top;
    t_pkt        r_pkt;
    t_dec        n_d4;
    logic        n_long;
    logic [2:0]  n_top;
    t_pkt        n_pkt;
    logic [55:0] m56;
    logic [55:0] m_al;
    logic [7:0]  hdr;
    logic [7:0]  e_hi;
    logic [7:0]  e_lo;

    assign rdy[2]  = !r_v[2] || !i_stall;
    assign rdy[1]  = !r_v[1] || rdy[2];
    assign rdy[0]  = !r_v[0] || rdy[1];
    assign o_stall = !rdy[0];
    assign o_valid = r_v[2];
    assign o_pkt   = r_pkt;

    // stage 4: drop trailing zeros, raise exponent to match
    always_comb begin
        n_d4      = i_ctz.d;
        n_d4.mant = i_ctz.d.mant >> i_ctz.sh;
        n_d4.exp  = i_ctz.d.exp + $signed({6'd0, i_ctz.sh});
    end

    // stage 5: exponent length and highest nonzero mantissa byte
    always_comb begin
        m56    = {3'b000, r_d4.mant};
        n_long = !((&r_d4.exp[11:7]) || !(|r_d4.exp[11:7]));
        n_top  = 3'd0;
        for (int b = 0; b < 7; b++) begin
            if (|m56[8*b +: 8]) begin
                n_top = 3'(b);
            end
        end
    end

    // stage 6: header, exponent octets, left-aligned mantissa octets
    always_comb begin
        m_al  = {3'b000, r_d5.mant} << {(3'd6 - r_top), 3'b000};
        hdr   = HDR_BIN | (r_d5.neg ? HDR_NEG : 8'h00) | (r_long ? HDR_EXP2 : 8'h00);
        e_hi  = {{4{r_d5.exp[11]}}, r_d5.exp[11:8]};
        e_lo  = r_d5.exp[7:0];
        n_pkt.empty = r_d5.special && r_d5.empty;
        n_pkt.oct   = '0;
        if (r_d5.special) begin
            n_pkt.oct[0] = r_d5.sp_oct;
            n_pkt.n      = 4'd1;
        end else begin
            n_pkt.oct[0] = hdr;
            n_pkt.n      = 4'd3 + {3'b000, r_long} + {1'b0, r_top};
            if (r_long) begin
                n_pkt.oct[1] = e_hi;
                n_pkt.oct[2] = e_lo;
                for (int k = 0; k < 7; k++) begin
                    n_pkt.oct[3+k] = m_al[55-8*k -: 8];
                end
            end else begin
                n_pkt.oct[1] = e_lo;
                for (int k = 0; k < 7; k++) begin
                    n_pkt.oct[2+k] = m_al[55-8*k -: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 3'b000;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (rdy[1]) begin
                r_v[1] <= r_v[0];
            end
            if (rdy[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_d4 <= n_d4;
        end
        if (rdy[1] && r_v[0]) begin
            r_d5   <= r_d4;
            r_long <= n_long;
            r_top  <= n_top;
        end
        if (rdy[2] && r_v[1]) begin
            r_pkt <= n_pkt;
        end
    end

    // built length always within 1..10 octets
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_pkt.n != 4'd0 && r_pkt.n <= 4'(MAX_OCTETS)))
        else $error("packed length out of range");

    // the empty flag only rides on a single-octet encoding
    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && r_pkt.empty) |-> (r_pkt.n == 4'd1 && r_pkt.oct[0] == OCT_PZERO))
        else $error("empty encoding with octets");

endmodule

// File: rtl/der_ser.sv
// ----------------------------------------------------------------------------
// der_ser
// Output serializer: holds one built encoding and sends one octet per beat.
// Loads the next encoding on the beat that carries the last octet.
// ----------------------------------------------------------------------------
module der_ser import der_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_pkt       i_pkt,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_octet,
    output logic       o_last,
    output logic       o_empty_encoding
);

    logic                       r_busy;
    logic [3:0]                 r_left;
    logic [MAX_OCTETS-1:0][7:0] r_oct;
    logic                       r_empty;
    logic                       fire;
    logic                       load_ok;

    assign fire             = r_busy && !i_stall;
    assign load_ok          = !r_busy || (fire && r_left == 4'd1);
    assign o_stall          = !load_ok;
    assign o_valid          = r_busy;
    assign o_octet          = r_oct[0];
    assign o_last           = (r_left == 4'd1);
    assign o_empty_encoding = r_empty;

    // control: beat count and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= 4'd0;
        end else if (load_ok) begin
            r_busy <= i_valid;
            r_left <= i_valid ? i_pkt.n : 4'd0;
        end else if (fire) begin
            r_left <= r_left - 4'd1;
        end
    end

    // payload: load or shift toward octet 0
    always_ff @(posedge i_clk) begin
        if (load_ok && i_valid) begin
            r_oct   <= i_pkt.oct;
            r_empty <= i_pkt.empty;
        end else if (fire) begin
            r_oct <= {8'h00, r_oct[MAX_OCTETS-1:1]};
        end
    end

    // a busy serializer always has beats left
    a_busy_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != 4'd0))
        else $error("busy with no beats left");

    // a beat that is not the last keeps the encoding in flight
    a_keep_going: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_left != 4'd1) |=> (r_busy && r_left == $past(r_left) - 4'd1))
        else $error("encoding cut short");

endmodule

// File: rtl/der_real_encoder_unit.sv
// ----------------------------------------------------------------------------
// der_real_encoder_unit
// ASN.1 DER REAL content encoder for IEEE binary64 patterns.
//
//   channel | dir | signals                                   | flow ctl
//   --------+-----+-------------------------------------------+-----------
//   input   | in  | i_valid, i_float_bits                     | o_stall
//   output  | out | o_valid, o_octet, o_last, o_empty_encoding| i_stall
//
// Six register stages (decode, byte ctz, ctz select, shift, size, layout)
// feed a serializer, whose register presents the first octet. One octet
// leaves per cycle while i_stall is low, and each value leaves as 1 to 10
// octets, the count it was given at the serializer. Values enter every
// cycle until the stages fill. Reset is synchronous and clears only valid
// and count state. Stalls hold every full stage in place; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module der_real_encoder_unit import der_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_octet,
    output logic        o_last,
    output logic        o_empty_encoding
);

    logic dec_valid;
    logic dec_stall;
    t_dec dec_data;
    logic ctz_valid;
    logic ctz_stall;
    t_ctz ctz_data;
    logic pkt_valid;
    logic pkt_stall;
    t_pkt pkt_data;

    der_dec u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_float_bits (i_float_bits),
        .o_valid      (dec_valid),
        .i_stall      (dec_stall),
        .o_dec        (dec_data)
    );

    der_ctz u_ctz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_stall (dec_stall),
        .i_dec   (dec_data),
        .o_valid (ctz_valid),
        .i_stall (ctz_stall),
        .o_ctz   (ctz_data)
    );

    der_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ctz_valid),
        .o_stall (ctz_stall),
        .i_ctz   (ctz_data),
        .o_valid (pkt_valid),
        .i_stall (pkt_stall),
        .o_pkt   (pkt_data)
    );

    der_ser u_ser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (pkt_valid),
        .o_stall          (pkt_stall),
        .i_pkt            (pkt_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_octet          (o_octet),
        .o_last           (o_last),
        .o_empty_encoding (o_empty_encoding)
    );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks der_real_encoder_unit against an in-bench DER REAL encoder.
// Each accepted binary64 value is expanded into its expected content octets,
// and every output beat is compared in order against that list. Both sides
// see random idle gaps and stalls, with one stretch of full throughput.
// ----------------------------------------------------------------------------

// One expected output beat, tagged with the value that caused it
typedef struct packed {
    logic [63:0] src;
    logic [7:0]  octet;
    logic        last;
    logic        empty;
} der_beat_t;

class der_octet_scoreboard;
    der_beat_t pending_octets[$];
    int        errors = 0;

    task report(input string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    // Queue one expected beat at the tail
    function void expect_beat(input logic [63:0] src, input logic [7:0] octet,
                              input logic last, input logic empty);
        der_beat_t b;
        b.src   = src;
        b.octet = octet;
        b.last  = last;
        b.empty = empty;
        pending_octets.insert(pending_octets.size(), b);
    endfunction

    // Encode one accepted value into the octets the block must emit
    function void note_value(input logic [63:0] bits);
        logic        neg;
        logic [10:0] ebits;
        logic [51:0] frac;
        logic [63:0] mant;
        logic [7:0]  hdr;
        logic [15:0] ev;
        logic [7:0]  seq[10];
        int          cnt;
        int          ex;
        int          nbytes;
        neg   = bits[63];
        ebits = bits[62:52];
        frac  = bits[51:0];
        cnt   = 0;

        // Single-octet special values
        if (ebits == 11'h7FF) begin
            if (frac != 0)
                expect_beat(bits, der_pkg::OCT_NAN, 1'b1, 1'b0);
            else if (neg)
                expect_beat(bits, der_pkg::OCT_NINF, 1'b1, 1'b0);
            else
                expect_beat(bits, der_pkg::OCT_PINF, 1'b1, 1'b0);
            return;
        end
        if (ebits == 11'h000 && frac == 0) begin
            if (neg)
                expect_beat(bits, der_pkg::OCT_NZERO, 1'b1, 1'b0);
            else
                expect_beat(bits, der_pkg::OCT_PZERO, 1'b1, 1'b1);
            return;
        end

        // Unbiased exponent and mantissa, subnormals without hidden bit
        if (ebits != 11'h000) begin
            ex   = ebits;
            ex   = ex - 1075;
            mant = {11'b0, 1'b1, frac};
        end else begin
            ex   = -1074;
            mant = {12'b0, frac};
        end

        // Make the mantissa odd
        while (mant[0] == 1'b0) begin
            mant = mant >> 1;
            ex   = ex + 1;
        end

        // Header plus minimal two's complement exponent
        hdr = der_pkg::HDR_BIN | (neg ? der_pkg::HDR_NEG : 8'h00);
        ev  = ex[15:0];
        if (ex >= -128 && ex <= 127) begin
            seq[cnt] = hdr;
            cnt++;
            seq[cnt] = ev[7:0];
            cnt++;
        end else begin
            seq[cnt] = hdr | der_pkg::HDR_EXP2;
            cnt++;
            seq[cnt] = ev[15:8];
            cnt++;
            seq[cnt] = ev[7:0];
            cnt++;
        end

        // Minimal big-endian mantissa
        nbytes = 1;
        for (int i = 1; i < 8; i++)
            if ((mant >> (8 * i)) != 0)
                nbytes = i + 1;
        for (int i = nbytes - 1; i >= 0; i--) begin
            seq[cnt] = mant[8*i +: 8];
            cnt++;
        end

        for (int i = 0; i < cnt; i++)
            expect_beat(bits, seq[i], i == cnt - 1, 1'b0);
    endfunction

    // Compare one output beat with the oldest expected one
    task check_beat(input logic [7:0] octet, input logic last, input logic empty);
        der_beat_t want;
        if (pending_octets.size() == 0) begin
            report($sformatf("unexpected beat octet=%02h last=%0b empty=%0b",
                             octet, last, empty));
            return;
        end
        want = pending_octets.pop_front();
        if (octet !== want.octet)
            report($sformatf("value %016h: octet %02h, expected %02h",
                             want.src, octet, want.octet));
        if (last !== want.last)
            report($sformatf("value %016h: last %0b, expected %0b",
                             want.src, last, want.last));
        if (empty !== want.empty)
            report($sformatf("value %016h: empty %0b, expected %0b",
                             want.src, empty, want.empty));
    endtask

    function int pending();
        return pending_octets.size();
    endfunction
endclass

module testbench;
    import der_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 180;
    localparam int DRAIN_CYCLES = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [63:0] i_float_bits = 64'h0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_octet;
    logic        o_last;
    logic        o_empty_encoding;

    der_octet_scoreboard sb;
    bit                  no_idle = 1'b0;
    int                  quiet_cycles = 0;

    der_real_encoder_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_float_bits     (i_float_bits),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_octet          (o_octet),
        .o_last           (o_last),
        .o_empty_encoding (o_empty_encoding)
    );

    always #1 i_clk = ~i_clk;

    // Idle length: mostly none, some short, a few long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Random value, weighted toward interesting encodings
    function logic [63:0] pick_value();
        int          sel;
        logic        sgn;
        logic [10:0] ebits;
        logic [51:0] frac;
        sel  = $urandom_range(0, 99);
        sgn  = 1'($urandom_range(0, 1));
        frac = 52'({$urandom, $urandom});
        if (sel < 40)
            return {$urandom, $urandom};
        if (sel < 55) begin
            // short mantissas: trailing zeros of every length
            ebits = 11'($urandom_range(1, 2046));
            frac  = frac << $urandom_range(0, 51);
        end else if (sel < 65) begin
            ebits = 11'h000;
            frac  = frac >> $urandom_range(0, 51);
            if (frac == 0)
                frac = 52'h1;
        end else if (sel < 77) begin
            // exponents around the one/two octet boundary
            ebits = 11'($urandom_range(900, 1250));
            frac  = frac << $urandom_range(0, 51);
        end else if (sel < 88) begin
            case ($urandom_range(0, 2))
                0: return {sgn, 63'h0};
                1: return {sgn, 11'h7FF, 52'h0};
                default: begin
                    if (frac == 0)
                        frac = 52'h8_0000_0000_0000;
                    return {sgn, 11'h7FF, frac};
                end
            endcase
        end else begin
            ebits = $urandom_range(0, 1) ? 11'h001 : 11'h7FE;
        end
        return {sgn, ebits, frac};
    endfunction

    // Present one beat and hold it until taken
    task automatic send_value(input logic [63:0] bits);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_float_bits <= bits;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Output back-pressure
    initial begin
        @(posedge i_clk);
        forever begin
            int run;
            run = pick_gap();
            if (run > 0) begin
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Beat monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_value(i_float_bits);
            if (o_valid && !i_stall)
                sb.check_beat(o_octet, o_last, o_empty_encoding);
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [63:0] directed[$];
        sb = new();
        directed = '{
            64'h0000_0000_0000_0000,  // plus zero
            64'h8000_0000_0000_0000,  // minus zero
            64'h7FF0_0000_0000_0000,  // plus infinity
            64'hFFF0_0000_0000_0000,  // minus infinity
            64'h7FF8_0000_0000_0000,  // quiet NaN
            64'hFFF0_0000_0000_0001,  // negative NaN, low fraction bit
            64'h7FFF_FFFF_FFFF_FFFF,  // NaN, all fraction bits
            64'h3FF0_0000_0000_0000,  // 1.0
            64'hBFF0_0000_0000_0000,  // -1.0
            64'h4008_0000_0000_0000,  // 3.0
            64'h3FE0_0000_0000_0000,  // 0.5
            64'h0000_0000_0000_0001,  // smallest subnormal
            64'h8000_0000_0000_0001,  // negative smallest subnormal
            64'h000F_FFFF_FFFF_FFFF,  // largest subnormal
            64'h0010_0000_0000_0000,  // smallest normal
            64'h7FEF_FFFF_FFFF_FFFF,  // largest finite
            64'hFFEF_FFFF_FFFF_FFFF,  // most negative finite
            64'h3FF0_0000_0000_0001,  // full 53-bit odd mantissa
            64'h47E0_0000_0000_0000,  // exponent 127
            64'h47F0_0000_0000_0000,  // exponent 128
            64'h37F0_0000_0000_0000,  // exponent -128
            64'h37E0_0000_0000_0000,  // exponent -129
            64'h4330_0000_0000_00FF   // exponent 0, full 53-bit odd mantissa
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_value(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // one stretch at full rate on both sides
            no_idle = (n >= 60 && n < 100);
            send_value(pick_value());
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        // Drain, then watch for stray beats
        while (sb.pending() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: der_real_encoder_unit.f
rtl/der_pkg.sv
rtl/der_dec.sv
rtl/der_ctz.sv
rtl/der_pack.sv
rtl/der_ser.sv
rtl/der_real_encoder_unit.sv
bench/testbench.sv
